// ===== hdl/vpa_pkg.sv =====
package vpa_pkg;

    // Default sizes of the segment table and the fields.
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ADDR_BITS_DEF    = 32;
    localparam int ID_BITS_DEF      = 16;
    localparam int CNT_BITS         = 32;
    localparam longint MEM_SIZE_RST = 65536;

    // Configuration register indexes.
    localparam logic REG_FIT_STRATEGY = 1'b0;
    localparam logic REG_MEMORY_SIZE  = 1'b1;

    // Fit strategy codes.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_ALLOCATED  = 3'd0;
    localparam logic [2:0] ST_NO_FIT     = 3'd1;
    localparam logic [2:0] ST_FREED      = 3'd2;
    localparam logic [2:0] ST_BAD_ID     = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    // Table write data selects.
    localparam logic [2:0] WSEL_COPY   = 3'd0;
    localparam logic [2:0] WSEL_ALLOC  = 3'd1;
    localparam logic [2:0] WSEL_REMAIN = 3'd2;
    localparam logic [2:0] WSEL_MERGE  = 3'd3;
    localparam logic [2:0] WSEL_INIT   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       init;
        logic       latch;
        logic       scan;
        logic       rd_en;
        logic       wr_en;
        logic [2:0] wr_sel;
        logic       load;
        logic [2:0] status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic pick_vld;
        logic split;
        logic hit_vld;
        logic left_free;
        logic right_free;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/vpa_datapath.sv =====
module vpa_datapath #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 32,
    parameter int ID_BITS      = 16,
    parameter int IDX_W        = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vpa_pkg::t_cmd        i_cmd,
    input  logic [IDX_W-1:0]     i_rd_addr,
    input  logic [IDX_W-1:0]     i_wr_addr,
    output vpa_pkg::t_stat       o_stat,
    output logic [IDX_W-1:0]     o_pick_idx,
    output logic [IDX_W-1:0]     o_hit_idx,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [ADDR_BITS-1:0] i_cfg_data,
    input  logic                 i_opcode,
    input  logic [ADDR_BITS-1:0] i_request_bytes,
    input  logic [ID_BITS-1:0]   i_free_id,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [2:0]           o_status,
    output logic [ID_BITS-1:0]   o_granted_id,
    output logic [ADDR_BITS-1:0] o_granted_address,
    output logic [vpa_pkg::CNT_BITS-1:0] o_request_total,
    output logic [vpa_pkg::CNT_BITS-1:0] o_success_total,
    output logic [vpa_pkg::CNT_BITS-1:0] o_failure_total
);
    import vpa_pkg::*;

    localparam int LEN_W = ADDR_BITS + 1;

    // Segment table.
    logic [ADDR_BITS-1:0] m_start [MAX_SEGMENTS];
    logic [LEN_W-1:0]     m_len   [MAX_SEGMENTS];
    logic                 m_used  [MAX_SEGMENTS];
    logic [ID_BITS-1:0]   m_owner [MAX_SEGMENTS];

    logic [ADDR_BITS-1:0] r_rd_start;
    logic [LEN_W-1:0]     r_rd_len;
    logic                 r_rd_used;
    logic [ID_BITS-1:0]   r_rd_owner;

    logic [1:0]           r_fit;
    logic [ADDR_BITS-1:0] r_mem_size;

    logic                 r_op;
    logic [ADDR_BITS-1:0] r_want;
    logic [ID_BITS-1:0]   r_fid;

    logic                 r_eval_vld;
    logic [IDX_W-1:0]     r_eval_idx;

    logic                 r_pick_vld;
    logic [IDX_W-1:0]     r_pick_idx;
    logic [LEN_W-1:0]     r_pick_len;
    logic [ADDR_BITS-1:0] r_pick_start;

    logic                 r_hit_vld;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [LEN_W-1:0]     r_hit_len;
    logic [ADDR_BITS-1:0] r_hit_start;
    logic                 r_left_free;
    logic [LEN_W-1:0]     r_left_len;
    logic [ADDR_BITS-1:0] r_left_start;
    logic                 r_right_free;
    logic [LEN_W-1:0]     r_right_len;

    logic                 r_prev_used;
    logic [LEN_W-1:0]     r_prev_len;
    logic [ADDR_BITS-1:0] r_prev_start;

    logic [ID_BITS-1:0]   r_next_id;
    logic [ID_BITS-1:0]   n_next_id;
    logic [CNT_BITS-1:0]  r_req;
    logic [CNT_BITS-1:0]  r_ok;
    logic [CNT_BITS-1:0]  r_fail;

    logic                 r_out_vld;
    logic [2:0]           r_out_status;
    logic [ID_BITS-1:0]   r_out_id;
    logic [ADDR_BITS-1:0] r_out_addr;

    logic                 ev_fit;
    logic                 ev_match;
    logic                 ev_better;
    logic [LEN_W-1:0]     want_ext;

    logic [ADDR_BITS-1:0] wd_start;
    logic [LEN_W-1:0]     wd_len;
    logic                 wd_used;
    logic [ID_BITS-1:0]   wd_owner;

    assign want_ext = {1'b0, r_want};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit      <= FIT_FIRST;
            r_mem_size <= ADDR_BITS'(MEM_SIZE_RST);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FIT_STRATEGY) begin
                r_fit <= i_cfg_data[1:0];
            end else begin
                r_mem_size <= i_cfg_data;
            end
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_opcode;
            r_want <= i_request_bytes;
            r_fid  <= i_free_id;
        end
    end

    // Write data for the table.
    always_comb begin
        wd_start = r_rd_start;
        wd_len   = r_rd_len;
        wd_used  = r_rd_used;
        wd_owner = r_rd_owner;
        case (i_cmd.wr_sel)
            WSEL_COPY: begin
            end
            WSEL_ALLOC: begin
                wd_start = r_pick_start;
                wd_len   = want_ext;
                wd_used  = 1'b1;
                wd_owner = r_next_id;
            end
            WSEL_REMAIN: begin
                wd_start = r_pick_start + r_want;
                wd_len   = r_pick_len - want_ext;
                wd_used  = 1'b0;
                wd_owner = '0;
            end
            WSEL_MERGE: begin
                wd_start = r_left_free ? r_left_start : r_hit_start;
                wd_len   = (r_left_free ? r_left_len : '0) + r_hit_len
                         + (r_right_free ? r_right_len : '0);
                wd_used  = 1'b0;
                wd_owner = '0;
            end
            WSEL_INIT: begin
                wd_start = '0;
                wd_len   = {1'b0, r_mem_size};
                wd_used  = 1'b0;
                wd_owner = '0;
            end
            default: begin
            end
        endcase
    end

    // Table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            m_start[i_wr_addr] <= wd_start;
            m_len[i_wr_addr]   <= wd_len;
            m_used[i_wr_addr]  <= wd_used;
            m_owner[i_wr_addr] <= wd_owner;
        end
        if (i_cmd.rd_en) begin
            r_rd_start <= m_start[i_rd_addr];
            r_rd_len   <= m_len[i_rd_addr];
            r_rd_used  <= m_used[i_rd_addr];
            r_rd_owner <= m_owner[i_rd_addr];
        end
    end

    // Scan read data arrives in the cycle after its read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_vld <= 1'b0;
        end else begin
            r_eval_vld <= i_cmd.rd_en && i_cmd.scan;
        end
        r_eval_idx <= i_rd_addr;
    end

    // Entry evaluation for both fit search and id match.
    always_comb begin
        ev_fit    = !r_rd_used && (r_rd_len >= want_ext);
        ev_match  = r_rd_used && (r_rd_owner == r_fid);
        ev_better = !r_pick_vld
                  || ((r_fit == FIT_BEST) && (r_rd_len < r_pick_len))
                  || ((r_fit == FIT_WORST) && (r_rd_len > r_pick_len));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_pick_vld   <= 1'b0;
            r_hit_vld    <= 1'b0;
            r_right_free <= 1'b0;
            r_left_free  <= 1'b0;
            r_prev_used  <= 1'b1;
        end else if (r_eval_vld) begin
            r_prev_used  <= r_rd_used;
            r_prev_len   <= r_rd_len;
            r_prev_start <= r_rd_start;
            if (ev_fit && ev_better) begin
                r_pick_vld   <= 1'b1;
                r_pick_idx   <= r_eval_idx;
                r_pick_len   <= r_rd_len;
                r_pick_start <= r_rd_start;
            end
            if (!r_hit_vld && ev_match) begin
                r_hit_vld    <= 1'b1;
                r_hit_idx    <= r_eval_idx;
                r_hit_len    <= r_rd_len;
                r_hit_start  <= r_rd_start;
                r_left_free  <= (r_eval_idx != '0) && !r_prev_used;
                r_left_len   <= r_prev_len;
                r_left_start <= r_prev_start;
            end
            if (r_hit_vld && ({1'b0, r_eval_idx} == {1'b0, r_hit_idx} + 1'b1)) begin
                r_right_free <= !r_rd_used;
                r_right_len  <= r_rd_len;
            end
        end
    end

    // Identifier advance skips zero.
    always_comb begin
        n_next_id = r_next_id + 1'b1;
        if (n_next_id == '0) begin
            n_next_id = ID_BITS'(1);
        end
    end

    // Counters, identifier and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_next_id <= ID_BITS'(1);
            r_req     <= '0;
            r_ok      <= '0;
            r_fail    <= '0;
        end else if (i_cmd.init) begin
            r_next_id <= ID_BITS'(1);
            r_req     <= '0;
            r_ok      <= '0;
            r_fail    <= '0;
        end else if (i_cmd.load) begin
            r_out_vld <= 1'b1;
            if (r_op == OP_ALLOC) begin
                r_req <= r_req + 1'b1;
                if (i_cmd.status == ST_ALLOCATED) begin
                    r_ok      <= r_ok + 1'b1;
                    r_next_id <= n_next_id;
                end else begin
                    r_fail <= r_fail + 1'b1;
                end
            end
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status <= i_cmd.status;
            r_out_id     <= (i_cmd.status == ST_ALLOCATED) ? r_next_id : '0;
            r_out_addr   <= (i_cmd.status == ST_ALLOCATED) ? r_pick_start : '0;
        end
    end

    assign o_stat.is_free    = (r_op == OP_FREE);
    assign o_stat.pick_vld   = r_pick_vld;
    assign o_stat.split      = r_pick_len > want_ext;
    assign o_stat.hit_vld    = r_hit_vld;
    assign o_stat.left_free  = r_left_free;
    assign o_stat.right_free = r_right_free;
    assign o_stat.out_free   = !r_out_vld || i_ready;
    assign o_pick_idx        = r_pick_idx;
    assign o_hit_idx         = r_hit_idx;

    assign o_valid           = r_out_vld;
    assign o_status          = r_out_status;
    assign o_granted_id      = r_out_id;
    assign o_granted_address = r_out_addr;
    assign o_request_total   = r_req;
    assign o_success_total   = r_ok;
    assign o_failure_total   = r_fail;

endmodule

// ===== hdl/vpa_ctrl.sv =====
module vpa_ctrl #(
    parameter int MAX_SEGMENTS = 64,
    parameter int IDX_W        = 6,
    parameter int CNT_W        = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_rebuild,
    input  vpa_pkg::t_stat    i_stat,
    input  logic [IDX_W-1:0]  i_pick_idx,
    input  logic [IDX_W-1:0]  i_hit_idx,
    output vpa_pkg::t_cmd     o_cmd,
    output logic [IDX_W-1:0]  o_rd_addr,
    output logic [IDX_W-1:0]  o_wr_addr
);
    import vpa_pkg::*;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_DRAIN    = 4'd3;
    localparam logic [3:0] S_DECIDE   = 4'd4;
    localparam logic [3:0] S_SHIFT    = 4'd5;
    localparam logic [3:0] S_WR_REM   = 4'd6;
    localparam logic [3:0] S_WR_ALLOC = 4'd7;
    localparam logic [3:0] S_WR_MERGE = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_src;
    logic [CNT_W-1:0] r_n;
    logic [1:0]       r_d;
    logic             r_up;
    logic             r_cp_vld;
    logic [IDX_W-1:0] r_cp_addr;
    logic [2:0]       r_status;

    logic [CNT_W-1:0] pick_ext;
    logic [CNT_W-1:0] hit_ext;
    logic [CNT_W-1:0] dst0;
    logic [CNT_W-1:0] src0;
    logic [1:0]       d_free;
    logic             accept;

    assign pick_ext = CNT_W'(i_pick_idx);
    assign hit_ext  = CNT_W'(i_hit_idx);
    assign d_free   = {1'b0, i_stat.left_free} + {1'b0, i_stat.right_free};
    assign dst0     = i_stat.left_free ? hit_ext : hit_ext + 1'b1;
    assign src0     = dst0 + CNT_W'(d_free);
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     n_state = S_IDLE;
            S_IDLE:     n_state = accept ? S_SCAN : S_IDLE;
            S_SCAN:     n_state = (r_ptr == r_count - 1'b1) ? S_DRAIN : S_SCAN;
            S_DRAIN:    n_state = S_DECIDE;
            S_DECIDE: begin
                if (!i_stat.is_free) begin
                    if (!i_stat.pick_vld) begin
                        n_state = S_DONE;
                    end else if (i_stat.split && (r_count == CNT_MAX)) begin
                        n_state = S_DONE;
                    end else if (!i_stat.split) begin
                        n_state = S_WR_ALLOC;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_state = i_stat.hit_vld ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT: begin
                if ((r_n == '0) && !r_cp_vld) begin
                    n_state = r_up ? S_WR_REM : S_WR_MERGE;
                end
            end
            S_WR_REM:   n_state = S_WR_ALLOC;
            S_WR_ALLOC: n_state = S_DONE;
            S_WR_MERGE: n_state = S_DONE;
            S_DONE:     n_state = i_stat.out_free ? S_IDLE : S_DONE;
            default:    n_state = S_INIT;
        endcase
        if (i_rebuild) begin
            n_state = S_INIT;
        end
    end

    // State, table size and the shift engine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_count  <= CNT_W'(1);
            r_cp_vld <= 1'b0;
            r_n      <= '0;
        end else begin
            r_state  <= n_state;
            r_cp_vld <= 1'b0;
            case (r_state)
                S_INIT: r_count <= CNT_W'(1);
                S_IDLE: r_ptr <= '0;
                S_SCAN: r_ptr <= r_ptr + 1'b1;
                S_DECIDE: begin
                    if (!i_stat.is_free) begin
                        if (!i_stat.pick_vld) begin
                            r_status <= ST_NO_FIT;
                        end else if (i_stat.split && (r_count == CNT_MAX)) begin
                            r_status <= ST_TABLE_FULL;
                        end else begin
                            r_status <= ST_ALLOCATED;
                        end
                        r_up  <= 1'b1;
                        r_src <= r_count - 1'b1;
                        r_n   <= r_count - pick_ext - 1'b1;
                        r_d   <= 2'd1;
                    end else begin
                        r_status <= i_stat.hit_vld ? ST_FREED : ST_BAD_ID;
                        r_up  <= 1'b0;
                        r_src <= src0;
                        r_n   <= (r_count > src0) ? r_count - src0 : '0;
                        r_d   <= d_free;
                    end
                end
                S_SHIFT: begin
                    if (r_n != '0) begin
                        r_n       <= r_n - 1'b1;
                        r_src     <= r_up ? r_src - 1'b1 : r_src + 1'b1;
                        r_cp_vld  <= 1'b1;
                        r_cp_addr <= r_up ? IDX_W'(r_src + 1'b1)
                                          : IDX_W'(r_src - CNT_W'(r_d));
                    end
                end
                S_WR_REM:   r_count <= r_count + 1'b1;
                S_WR_MERGE: r_count <= r_count - CNT_W'(r_d);
                default: begin
                end
            endcase
        end
    end

    // Command outputs.
    always_comb begin
        o_cmd        = '0;
        o_cmd.status = r_status;
        o_rd_addr    = IDX_W'(r_ptr);
        o_wr_addr    = r_cp_addr;
        o_cmd.latch  = accept;
        case (r_state)
            S_INIT: begin
                o_cmd.init   = 1'b1;
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WSEL_INIT;
                o_wr_addr    = '0;
            end
            S_SCAN: begin
                o_cmd.scan  = 1'b1;
                o_cmd.rd_en = 1'b1;
            end
            S_SHIFT: begin
                o_cmd.rd_en  = (r_n != '0);
                o_rd_addr    = IDX_W'(r_src);
                o_cmd.wr_en  = r_cp_vld;
                o_cmd.wr_sel = WSEL_COPY;
            end
            S_WR_REM: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WSEL_REMAIN;
                o_wr_addr    = IDX_W'(pick_ext + 1'b1);
            end
            S_WR_ALLOC: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WSEL_ALLOC;
                o_wr_addr    = i_pick_idx;
            end
            S_WR_MERGE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WSEL_MERGE;
                o_wr_addr    = i_stat.left_free ? i_hit_idx - 1'b1 : i_hit_idx;
            end
            S_DONE: o_cmd.load = i_stat.out_free;
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // The table always holds at least one segment and never more than it has room for.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CNT_MAX))
        else $error("segment count out of range");

    // A split only runs when there is room for the extra segment.
    a_split_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_REM) |-> (r_count < CNT_MAX))
        else $error("split with a full table");

    // Copies only happen inside the shift sequence.
    a_copy_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_vld |-> (r_state == S_SHIFT))
        else $error("table copy outside shift");

    // A full table refusal never writes the table.
    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_status == ST_TABLE_FULL)) |-> !o_cmd.wr_en)
        else $error("table written on a refused request");
`endif

endmodule

// ===== hdl/variable_partition_allocator_top.sv =====
// Variable partition memory allocator with first, best or worst fit.
// Input channel: i_valid/o_ready with i_opcode (allocate or free),
// i_request_bytes and i_free_id. Output channel: o_valid/i_ready with
// the status, granted id and address, and the three request counters.
// Configuration: i_cfg_we with i_cfg_idx and i_cfg_data; index 0 sets the
// fit strategy, index 1 sets the memory size and rebuilds the table.
// Each request scans every segment in the table, one per cycle through the
// table's single read port, then shifts entries to open or close a gap,
// one per cycle, and writes the changed entries.
// After reset, and after a memory size write, the table is set to a
// single free segment and the counters clear; o_ready is low meanwhile.
// The result sits in an output register; while the receiver stalls, the
// next request is still accepted and worked, and its result waits until
// the register frees.
module variable_partition_allocator_top #(
    parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = vpa_pkg::ADDR_BITS_DEF,
    parameter int ID_BITS      = vpa_pkg::ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [ADDR_BITS-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_opcode,
    input  logic [ADDR_BITS-1:0] i_request_bytes,
    input  logic [ID_BITS-1:0]   i_free_id,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_status,
    output logic [ID_BITS-1:0]   o_granted_id,
    output logic [ADDR_BITS-1:0] o_granted_address,
    output logic [vpa_pkg::CNT_BITS-1:0] o_request_total,
    output logic [vpa_pkg::CNT_BITS-1:0] o_success_total,
    output logic [vpa_pkg::CNT_BITS-1:0] o_failure_total
);
    import vpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    t_cmd             cmd;
    t_stat            stat;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] pick_idx;
    logic [IDX_W-1:0] hit_idx;
    logic             rebuild;

    // A memory size write rebuilds the table.
    assign rebuild = i_cfg_we && (i_cfg_idx == REG_MEMORY_SIZE);

    vpa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rebuild  (rebuild),
        .i_stat     (stat),
        .i_pick_idx (pick_idx),
        .i_hit_idx  (hit_idx),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr)
    );

    vpa_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS),
        .ID_BITS      (ID_BITS),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_rd_addr         (rd_addr),
        .i_wr_addr         (wr_addr),
        .o_stat            (stat),
        .o_pick_idx        (pick_idx),
        .o_hit_idx         (hit_idx),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_request_bytes   (i_request_bytes),
        .i_free_id         (i_free_id),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_granted_id      (o_granted_id),
        .o_granted_address (o_granted_address),
        .o_request_total   (o_request_total),
        .o_success_total   (o_success_total),
        .o_failure_total   (o_failure_total)
    );

endmodule
